>>> hw/rtl/gwm_pkg.sv
// Shared types, codes and helpers of the glob wildcard matcher.
package gwm_pkg;

    localparam int unsigned MAX_PATTERN_DEF = 32;
    localparam int unsigned SYM_W           = 8;
    localparam int unsigned CMD_W           = 2;
    localparam int unsigned RES_W           = 2;
    localparam int unsigned RES_TDATA_W     = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    localparam logic [SYM_W-1:0] WILD_ONE = 8'h3F;  // '?'
    localparam logic [SYM_W-1:0] WILD_RUN = 8'h2A;  // '*'
    localparam logic [SYM_W-1:0] UPPER_A  = 8'h41;
    localparam logic [SYM_W-1:0] UPPER_Z  = 8'h5A;
    localparam logic [SYM_W-1:0] CASE_GAP = 8'h20;

    // Broadcast from the control logic to every position cell.
    typedef struct packed {
        logic             rearm;
        logic             step;
        logic [SYM_W-1:0] sym;
    } cell_ctrl_t;

    function automatic logic [SYM_W-1:0] fold_case(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z) begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/gwm_cell.sv
// One pattern position: stored pattern byte plus its active bit.
module gwm_cell #(
    parameter bit HEAD = 1'b0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gwm_pkg::cell_ctrl_t ctrl,
    input  logic                wr_en,
    input  logic                occupied,
    input  logic                cur_in,   // empty-run closure from left neighbor
    input  logic                adv_in,   // one-byte advance from left neighbor
    output logic                cur_out,
    output logic                star_out,
    output logic                adv_out
);

    logic [gwm_pkg::SYM_W-1:0] pat_reg;
    logic                      act_reg;
    logic                      act_next;
    logic                      is_star;
    logic                      hit;

    assign cur_out  = act_reg | cur_in;
    assign is_star  = (pat_reg == gwm_pkg::WILD_RUN);
    assign hit      = (pat_reg == gwm_pkg::WILD_ONE) || (pat_reg == ctrl.sym);
    assign star_out = cur_out & occupied & is_star;
    assign adv_out  = cur_out & occupied & ~is_star & hit;

    always_comb begin
        act_next = act_reg;
        if (ctrl.rearm) begin
            act_next = HEAD;
        end else if (ctrl.step) begin
            act_next = star_out | adv_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= HEAD;
        end else begin
            act_reg <= act_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pat_reg <= ctrl.sym;
        end
    end

endmodule

>>> hw/rtl/gwm_out_buf.sv
// Two-entry result buffer between the matcher and the output stream.
module gwm_out_buf #(
    parameter int unsigned W = gwm_pkg::RES_TDATA_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         in_ready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [W-1:0] m_tdata
);

    logic [W-1:0] head_reg, head_next;
    logic [W-1:0] tail_reg, tail_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = head_reg;
    assign in_ready = (cnt_reg != 2'd2);
    assign pop      = m_tvalid & m_tready;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (push && !pop) begin
            if (cnt_reg == 2'd0) begin
                head_next = push_data;
            end else begin
                tail_next = push_data;
            end
            cnt_next = cnt_reg + 2'd1;
        end else if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                head_next = push_data;
            end else begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end else if (pop) begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && cnt_reg == 2'd2))
        else $error("result pushed into full buffer");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && cnt_reg == 2'd0) |=> (m_tvalid && m_tdata == $past(push_data)))
        else $error("result pushed into empty buffer not presented");

endmodule

>>> hw/rtl/glob_wildcard_matcher_unit.sv
// Top level of the case-insensitive glob matcher ('?' and '*').
//
//  channel | dir | ports                  | per transfer
//  --------+-----+------------------------+--------------------------------------
//  input   | in  | s_tvalid/s_tready      | command in tuser, symbol in tdata
//  result  | out | m_tvalid/m_tready      | matched, pattern_overflow in tdata
//
// One input transfer per cycle while s_tready is high, any command mix.
// Every transfer but an append to a full pattern updates the cell row at the
// edge it is taken; the longest path is the empty-run chain rippling through
// all MAX_PATTERN cells, carry-chain style. End of text pushes its result
// into the buffer feeding m_. A two-entry result buffer lets input flow while
// a result waits; s_tready drops only when both entries hold results not yet taken.
// Reset (aresetn low, synchronous): empty pattern, no overflow, only
// position zero active, result buffer empty. No clearing pass is needed.
module glob_wildcard_matcher_unit #(
    parameter int unsigned MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gwm_pkg::SYM_W-1:0]         s_tdata,   // [7:0] symbol
    input  logic [gwm_pkg::CMD_W-1:0]         s_tuser,   // [1:0] command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gwm_pkg::RES_TDATA_W-1:0]   m_tdata    // [0] matched,
                                                         // [1] pattern_overflow,
                                                         // [7:2] zero
);

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

    gwm_pkg::cmd_t       cmd;
    gwm_pkg::cell_ctrl_t ctrl;
    logic                take;
    logic                append_go;
    logic                end_go;
    logic                room;

    logic [LEN_W-1:0]    len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic                act_last_reg, act_last_next;

    // Per-position wiring of the cell row; index MAX_PATTERN is the final spot.
    logic [MAX_PATTERN:0]   cur_vec;
    logic [MAX_PATTERN-1:0] star_vec;
    logic [MAX_PATTERN-1:0] adv_vec;
    logic [MAX_PATTERN-1:0] wr_vec;
    logic [MAX_PATTERN-1:0] occ_vec;

    logic                                res_push;
    logic [gwm_pkg::RES_TDATA_W-1:0]     res_data;

    assign take = s_tvalid & s_tready;
    assign cmd  = gwm_pkg::cmd_t'(s_tuser);
    assign room = (len_reg < LEN_W'(MAX_PATTERN));

    // Command decode.
    always_comb begin
        ctrl.rearm = 1'b0;
        ctrl.step  = 1'b0;
        ctrl.sym   = gwm_pkg::fold_case(s_tdata);
        append_go  = 1'b0;
        end_go     = 1'b0;
        if (take) begin
            unique case (cmd)
                gwm_pkg::CMD_CLEAR:  ctrl.rearm = 1'b1;
                gwm_pkg::CMD_APPEND: append_go  = 1'b1;
                gwm_pkg::CMD_TEXT:   ctrl.step  = 1'b1;
                gwm_pkg::CMD_END: begin
                    ctrl.rearm = 1'b1;
                    end_go     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Pattern length and overflow flag.
    always_comb begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (take && cmd == gwm_pkg::CMD_CLEAR) begin
            len_next = '0;
            ovf_next = 1'b0;
        end else if (append_go) begin
            if (room) begin
                len_next = len_reg + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    // Cell row: each cell passes closure and advance to its right neighbor.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
            logic cin;
            logic ain;
            if (gi == 0) begin : g_head
                assign cin = 1'b0;
                assign ain = 1'b0;
            end else begin : g_body
                assign cin = star_vec[gi-1];
                assign ain = adv_vec[gi-1];
            end

            assign wr_vec[gi]  = append_go & room & (len_reg == LEN_W'(gi));
            assign occ_vec[gi] = (LEN_W'(gi) < len_reg);

            gwm_cell #(
                .HEAD (gi == 0)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .wr_en    (wr_vec[gi]),
                .occupied (occ_vec[gi]),
                .cur_in   (cin),
                .adv_in   (ain),
                .cur_out  (cur_vec[gi]),
                .star_out (star_vec[gi]),
                .adv_out  (adv_vec[gi])
            );
        end
    endgenerate

    // Final position past the last pattern byte.
    assign cur_vec[MAX_PATTERN] = act_last_reg | star_vec[MAX_PATTERN-1];

    always_comb begin
        act_last_next = act_last_reg;
        if (ctrl.rearm) begin
            act_last_next = 1'b0;
        end else if (ctrl.step) begin
            act_last_next = adv_vec[MAX_PATTERN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            act_last_reg <= 1'b0;
        end else begin
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            act_last_reg <= act_last_next;
        end
    end

    // Result: whole-text match is the active bit at the current pattern end.
    assign res_push = end_go;
    assign res_data = {{(gwm_pkg::RES_TDATA_W - gwm_pkg::RES_W){1'b0}},
                       ovf_reg, cur_vec[len_reg]};

    gwm_out_buf #(
        .W (gwm_pkg::RES_TDATA_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && cmd == gwm_pkg::CMD_CLEAR) |=> (len_reg == '0 && !ovf_reg))
        else $error("clear did not empty the pattern");

    a_full_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (append_go && !room) |=> (ovf_reg && $stable(len_reg)))
        else $error("append into full store not flagged");

endmodule
